// File: hdl/lis_pkg.sv
// ----------------------------------------------------------------------------
// lis_pkg
// Shared constants and word types for the longest increasing subsequence
// block.
// ----------------------------------------------------------------------------
`default_nettype none

package lis_pkg;

  // Store capacity and derived widths
  localparam int MAX_ELEMENTS = 1024;
  localparam int ADDR_W       = $clog2(MAX_ELEMENTS);
  localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);

  // Fixed field widths of the channel words
  localparam int VALUE_W = 32;
  localparam int LEN_W   = 11;

  // Input word: one sequence element
  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      last;
  } in_word_t;

  // Result word: reported on the last element
  typedef struct packed {
    logic [LEN_W-1:0] lis_length;
    logic             overflow;
  } out_word_t;

endpackage

`default_nettype wire

// File: hdl/longest_increasing_subsequence_top.sv
// ----------------------------------------------------------------------------
// longest_increasing_subsequence_top
// Longest strictly increasing subsequence over a stream of signed words.
//
// Usage: in_valid/in_data carry one element per word, in_data.last marks the
// final element of a sequence. Each element is compared against every
// stored element by one shared compare unit, one stored entry per cycle,
// reading the value and length stores through a single registered read port.
// An element that lands at store position n > 0 passes the scan state (n
// reads, each compared once its registered data arrives), the write state
// and idle, which takes the next word; in_stall is high in all but idle.
// A sequence's first element skips the scan, a word dropped on a full store
// the write; a last one adds a result-loading state. out_valid/out_data carry
// one result word per sequence: the longest increasing subsequence length
// and an overflow flag for elements dropped on a full store. The result
// sits in an output register, so the next element is taken while it waits;
// if out_stall holds a result and another last element finishes, the block
// waits in its final state until the register frees up. After each result
// the count, running maximum and overflow flag return to zero. Reset clears
// the control state only; store entries are written before they are read.
// ----------------------------------------------------------------------------
`default_nettype none

module longest_increasing_subsequence_top (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire lis_pkg::in_word_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output lis_pkg::out_word_t      out_data
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_WRITE  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // Sequence state
  logic [lis_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [lis_pkg::CNT_W-1:0] best_r, best_nxt;
  logic                      ovf_r, ovf_nxt;

  // Current element
  logic signed [lis_pkg::VALUE_W-1:0] cur_val_r, cur_val_nxt;
  logic                               cur_last_r, cur_last_nxt;
  logic [lis_pkg::CNT_W-1:0]          longest_r, longest_nxt;

  // Scan pipeline
  logic [lis_pkg::CNT_W-1:0] issue_r, issue_nxt;
  logic                      rd_en;
  logic                      vld_r, vld_nxt;
  logic                      lastf_r, lastf_nxt;

  // Stores and registered read data
  logic signed [lis_pkg::VALUE_W-1:0] val_mem [lis_pkg::MAX_ELEMENTS];
  logic [lis_pkg::CNT_W-1:0]          len_mem [lis_pkg::MAX_ELEMENTS];
  logic signed [lis_pkg::VALUE_W-1:0] rd_val_r;
  logic [lis_pkg::CNT_W-1:0]          rd_len_r;
  logic                               wr_en;
  logic [lis_pkg::CNT_W-1:0]          new_len;

  // Output register
  logic               out_valid_r, out_valid_nxt;
  lis_pkg::out_word_t out_data_r, out_data_nxt;
  logic               in_acc;
  logic               out_free;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign new_len   = longest_r + lis_pkg::CNT_W'(1);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Store write and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      val_mem[cnt_r[lis_pkg::ADDR_W-1:0]] <= cur_val_r;
      len_mem[cnt_r[lis_pkg::ADDR_W-1:0]] <= new_len;
    end
    if (rd_en) begin
      rd_val_r <= val_mem[issue_r[lis_pkg::ADDR_W-1:0]];
      rd_len_r <= len_mem[issue_r[lis_pkg::ADDR_W-1:0]];
    end
  end

  // Sequencer and shared compare unit
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    best_nxt      = best_r;
    ovf_nxt       = ovf_r;
    cur_val_nxt   = cur_val_r;
    cur_last_nxt  = cur_last_r;
    longest_nxt   = longest_r;
    issue_nxt     = issue_r;
    vld_nxt       = 1'b0;
    lastf_nxt     = 1'b0;
    rd_en         = 1'b0;
    wr_en         = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          cur_val_nxt  = in_data.value;
          cur_last_nxt = in_data.last;
          longest_nxt  = '0;
          issue_nxt    = '0;
          if (cnt_r == lis_pkg::CNT_W'(lis_pkg::MAX_ELEMENTS)) begin
            ovf_nxt   = 1'b1;
            state_nxt = in_data.last ? ST_FINISH : ST_IDLE;
          end else if (cnt_r == '0) begin
            state_nxt = ST_WRITE;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        // issue one read per cycle
        if (issue_r < cnt_r) begin
          rd_en     = 1'b1;
          issue_nxt = issue_r + lis_pkg::CNT_W'(1);
          vld_nxt   = 1'b1;
          lastf_nxt = (issue_r == cnt_r - lis_pkg::CNT_W'(1));
        end
        // compare the entry read last cycle
        if (vld_r) begin
          if ((rd_val_r < cur_val_r) && (rd_len_r > longest_r)) begin
            longest_nxt = rd_len_r;
          end
          if (lastf_r) begin
            state_nxt = ST_WRITE;
          end
        end
      end

      ST_WRITE: begin
        wr_en   = 1'b1;
        cnt_nxt = cnt_r + lis_pkg::CNT_W'(1);
        if (new_len > best_r) begin
          best_nxt = new_len;
        end
        state_nxt = cur_last_r ? ST_FINISH : ST_IDLE;
      end

      ST_FINISH: begin
        if (out_free) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.lis_length = lis_pkg::LEN_W'(best_r);
          out_data_nxt.overflow   = ovf_r;
          cnt_nxt                 = '0;
          best_nxt                = '0;
          ovf_nxt                 = 1'b0;
          state_nxt               = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      best_r      <= '0;
      ovf_r       <= 1'b0;
      vld_r       <= 1'b0;
      lastf_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      best_r      <= best_nxt;
      ovf_r       <= ovf_nxt;
      vld_r       <= vld_nxt;
      lastf_r     <= lastf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cur_val_r  <= cur_val_nxt;
    cur_last_r <= cur_last_nxt;
    longest_r  <= longest_nxt;
    issue_r    <= issue_nxt;
    out_data_r <= out_data_nxt;
  end

  // Store fill never passes capacity
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= lis_pkg::CNT_W'(lis_pkg::MAX_ELEMENTS))
    else $error("element count exceeds capacity");

  // Scan reads only entries already written
  a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (issue_r <= cnt_r))
    else $error("scan index beyond stored entries");

  // Running maximum covers the length just written
  a_best_cover: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WRITE) |=> (best_r >= $past(new_len)))
    else $error("running maximum below new length");

  // A new result only comes out of the finish state
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_FINISH))
    else $error("result loaded outside finish state");

endmodule

`default_nettype wire
